### sv/isotp_pkg.sv
// isotp_pkg: shared types, codes and constants of the segmented message receiver.
// Used by every module of the block; depends on nothing.
package isotp_pkg;

    localparam int MAX_MSG_BYTES_DEF = 4095;
    localparam int QUEUE_DEPTH       = 4;
    localparam int QPTR_W            = $clog2(QUEUE_DEPTH);
    localparam int JOB_BYTES         = 7;

    localparam logic [28:0] RX_ID_RESET   = 29'd0;
    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

    localparam logic       REG_RX_IDENTIFIER = 1'b0;
    localparam logic       REG_TIMEOUT_TICKS = 1'b1;

    localparam logic       ACT_FRAME = 1'b0;
    localparam logic       ACT_TICK  = 1'b1;

    localparam logic [3:0] PCI_SINGLE      = 4'h0;
    localparam logic [3:0] PCI_FIRST       = 4'h1;
    localparam logic [3:0] PCI_CONSECUTIVE = 4'h2;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_FLOW  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [1:0] ERR_BAD_SINGLE = 2'd0;
    localparam logic [1:0] ERR_BAD_FIRST  = 2'd1;
    localparam logic [1:0] ERR_SEQUENCE   = 2'd2;
    localparam logic [1:0] ERR_TIMEOUT    = 2'd3;

    typedef enum logic [1:0] {
        TAIL_NONE  = 2'd0,
        TAIL_FLOW  = 2'd1,
        TAIL_ERROR = 2'd2
    } tail_t;

    // One frame's or timeout tick's worth of results: count bytes, then an optional tail word.
    typedef struct packed {
        logic [JOB_BYTES-1:0][7:0] data;
        logic [2:0]                count;
        logic                      end_mark;
        tail_t                     tail;
        logic [1:0]                err;
    } job_t;

endpackage

### sv/isotp_segmented_receiver_top.sv
// isotp_segmented_receiver_top: ISO-TP style reassembly of CAN frames.
// Instantiates isotp_front, isotp_queue and isotp_back; depends on isotp_pkg.
//
//  channel  | handshake                  | word
//  ---------+----------------------------+--------------------------------------
//  item     | item_valid / item_stall    | action, can_id, frame_length, bytes
//  result   | result_valid / result_stall| kind, payload_byte, message_end, ...
//  config   | cfg_write                  | cfg_index, cfg_data
//
// One item word per cycle enters while the job queue has room; the front end
// settles reception state in the cycle of acceptance.
// Each frame gives 0 to 7 result words, one per cycle from the back end while
// result_stall is low; items without results put nothing into the job queue.
// Reset clears state and the queue at once; no sweep. A stalled result
// backs up into the queue, which then stalls the item side.
module isotp_segmented_receiver_top
    import isotp_pkg::*;
#(
    parameter int MAX_MESSAGE_BYTES = MAX_MSG_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [28:0] cfg_data,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic        action,
    input  logic [28:0] can_id,
    input  logic [3:0]  frame_length,
    input  logic [7:0]  byte_zero,
    input  logic [7:0]  byte_one,
    input  logic [7:0]  byte_two,
    input  logic [7:0]  byte_three,
    input  logic [7:0]  byte_four,
    input  logic [7:0]  byte_five,
    input  logic [7:0]  byte_six,
    input  logic [7:0]  byte_seven,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [1:0]  kind,
    output logic [7:0]  payload_byte,
    output logic        message_end,
    output logic [1:0]  error_code,
    output logic        run_last
);

    job_t job;
    job_t head;
    logic job_push;
    logic q_full;
    logic q_empty;
    logic q_pop;

    isotp_front #(
        .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .action      (action),
        .can_id      (can_id),
        .frame_length(frame_length),
        .byte_zero   (byte_zero),
        .byte_one    (byte_one),
        .byte_two    (byte_two),
        .byte_three  (byte_three),
        .byte_four   (byte_four),
        .byte_five   (byte_five),
        .byte_six    (byte_six),
        .byte_seven  (byte_seven),
        .queue_full  (q_full),
        .job_push    (job_push),
        .job         (job)
    );

    isotp_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (job_push),
        .push_job(job),
        .pop     (q_pop),
        .head    (head),
        .empty   (q_empty),
        .full    (q_full)
    );

    isotp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .queue_empty (q_empty),
        .pop         (q_pop),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .kind        (kind),
        .payload_byte(payload_byte),
        .message_end (message_end),
        .error_code  (error_code),
        .run_last    (run_last)
    );

endmodule

### sv/isotp_front.sv
// isotp_front: accepts words, keeps reception state and classifies each frame or tick
// into a job for the back end. Depends on isotp_pkg.
module isotp_front
    import isotp_pkg::*;
#(
    parameter int MAX_MESSAGE_BYTES = MAX_MSG_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [28:0] cfg_data,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic        action,
    input  logic [28:0] can_id,
    input  logic [3:0]  frame_length,
    input  logic [7:0]  byte_zero,
    input  logic [7:0]  byte_one,
    input  logic [7:0]  byte_two,
    input  logic [7:0]  byte_three,
    input  logic [7:0]  byte_four,
    input  logic [7:0]  byte_five,
    input  logic [7:0]  byte_six,
    input  logic [7:0]  byte_seven,
    input  logic        queue_full,
    output logic        job_push,
    output job_t        job
);

    localparam logic [11:0] MAX_SIZE = 12'(MAX_MESSAGE_BYTES);

    logic [28:0] rx_id_reg;
    logic [15:0] timeout_reg;
    logic        receiving_reg, receiving_next;
    logic [3:0]  seq_reg, seq_next;
    logic [11:0] rem_reg, rem_next;
    logic [15:0] tick_reg, tick_next;

    logic [7:0]  b [8];
    logic [3:0]  len;
    logic [3:0]  pci;
    logic [3:0]  low_nib;
    logic [11:0] size;
    logic [2:0]  have;
    logic [2:0]  avail;
    logic [2:0]  cf_n;
    logic [15:0] tick_inc;
    logic        from_two;
    logic        accept;

    assign item_stall = queue_full;
    assign accept     = item_valid && !queue_full;

    assign b[0] = byte_zero;
    assign b[1] = byte_one;
    assign b[2] = byte_two;
    assign b[3] = byte_three;
    assign b[4] = byte_four;
    assign b[5] = byte_five;
    assign b[6] = byte_six;
    assign b[7] = byte_seven;

    assign len      = (frame_length > 4'd8) ? 4'd8 : frame_length;
    assign pci      = byte_zero[7:4];
    assign low_nib  = byte_zero[3:0];
    assign size     = {low_nib, byte_one};
    assign have     = 3'(len - 4'd2);
    assign avail    = 3'(len - 4'd1);
    assign cf_n     = ({9'd0, avail} > rem_reg) ? rem_reg[2:0] : avail;
    assign tick_inc = (tick_reg != 16'hFFFF) ? tick_reg + 16'd1 : tick_reg;

    always_comb
    begin
        receiving_next = receiving_reg;
        seq_next       = seq_reg;
        rem_next       = rem_reg;
        tick_next      = tick_reg;
        from_two       = 1'b0;
        job_push       = 1'b0;
        job.count      = 3'd0;
        job.end_mark   = 1'b0;
        job.tail       = TAIL_NONE;
        job.err        = ERR_BAD_SINGLE;

        if (action == ACT_TICK)
        begin
            if (receiving_reg)
            begin
                tick_next = tick_inc;
                if (tick_inc >= timeout_reg)
                begin
                    job_push       = 1'b1;
                    job.tail       = TAIL_ERROR;
                    job.err        = ERR_TIMEOUT;
                    receiving_next = 1'b0;
                    seq_next       = 4'd0;
                    rem_next       = 12'd0;
                    tick_next      = 16'd0;
                end
            end
        end
        else if (len != 4'd0 && can_id == rx_id_reg)
        begin
            if (!receiving_reg)
            begin
                if (pci == PCI_SINGLE)
                begin
                    if ({1'b0, len} < {1'b0, low_nib} + 5'd1)
                    begin
                        job_push = 1'b1;
                        job.tail = TAIL_ERROR;
                        job.err  = ERR_BAD_SINGLE;
                    end
                    else
                    begin
                        job_push     = (low_nib != 4'd0);
                        job.count    = low_nib[2:0];
                        job.end_mark = 1'b1;
                    end
                end
                else if (pci == PCI_FIRST)
                begin
                    from_two = 1'b1;
                    if (len < 4'd2 || size > MAX_SIZE)
                    begin
                        job_push = 1'b1;
                        job.tail = TAIL_ERROR;
                        job.err  = ERR_BAD_FIRST;
                    end
                    else if ({9'd0, have} >= size)
                    begin
                        job_push     = (size != 12'd0);
                        job.count    = size[2:0];
                        job.end_mark = 1'b1;
                    end
                    else
                    begin
                        job_push       = 1'b1;
                        job.count      = have;
                        job.tail       = TAIL_FLOW;
                        receiving_next = 1'b1;
                        seq_next       = 4'd1;
                        rem_next       = size - {9'd0, have};
                        tick_next      = 16'd0;
                    end
                end
            end
            else if (pci == PCI_CONSECUTIVE)
            begin
                tick_next = 16'd0;
                if (low_nib != seq_reg)
                begin
                    job_push       = 1'b1;
                    job.tail       = TAIL_ERROR;
                    job.err        = ERR_SEQUENCE;
                    receiving_next = 1'b0;
                    seq_next       = 4'd0;
                    rem_next       = 12'd0;
                end
                else
                begin
                    seq_next     = seq_reg + 4'd1;
                    rem_next     = rem_reg - {9'd0, cf_n};
                    job_push     = (cf_n != 3'd0);
                    job.count    = cf_n;
                    job.end_mark = (rem_next == 12'd0);
                    if (rem_next == 12'd0)
                    begin
                        receiving_next = 1'b0;
                        seq_next       = 4'd0;
                    end
                end
            end
        end

        job_push = job_push && accept;

        for (int i = 0; i < JOB_BYTES; i++)
        begin
            if (!from_two)
                job.data[i] = b[i+1];
            else if (i + 2 < 8)
                job.data[i] = b[(i+2)%8];
            else
                job.data[i] = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_id_reg     <= RX_ID_RESET;
            timeout_reg   <= TIMEOUT_RESET;
            receiving_reg <= 1'b0;
            seq_reg       <= 4'd0;
            rem_reg       <= 12'd0;
            tick_reg      <= 16'd0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == REG_RX_IDENTIFIER)
                    rx_id_reg <= cfg_data;
                else
                    timeout_reg <= cfg_data[15:0];
            end
            if (accept)
            begin
                receiving_reg <= receiving_next;
                seq_reg       <= seq_next;
                rem_reg       <= rem_next;
                tick_reg      <= tick_next;
            end
        end
    end

endmodule

### sv/isotp_queue.sv
// isotp_queue: short job queue between front and back end.
// Depends on isotp_pkg.
module isotp_queue
    import isotp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head,
    output logic empty,
    output logic full
);

    job_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg, rd_reg;
    logic [QPTR_W:0]   fill_reg;

    assign head  = slot_reg[rd_reg];
    assign empty = (fill_reg == '0);
    assign full  = (fill_reg == (QPTR_W+1)'(QUEUE_DEPTH));

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            if (push && !pop)
                fill_reg <= fill_reg + 1'b1;
            else if (pop && !push)
                fill_reg <= fill_reg - 1'b1;
        end
    end

endmodule

### sv/isotp_back.sv
// isotp_back: walks the head job and drives one result word per cycle, while the
// output is not stalled, through an output register. Depends on isotp_pkg.
module isotp_back
    import isotp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  job_t       head,
    input  logic       queue_empty,
    output logic       pop,
    output logic       result_valid,
    input  logic       result_stall,
    output logic [1:0] kind,
    output logic [7:0] payload_byte,
    output logic       message_end,
    output logic [1:0] error_code,
    output logic       run_last
);

    logic       valid_reg;
    logic [2:0] idx_reg, idx_next;
    logic [1:0] kind_reg, kind_next;
    logic [7:0] byte_reg, byte_next;
    logic       end_reg, end_next;
    logic [1:0] err_reg, err_next;
    logic       last_reg, last_next;
    logic       load;
    logic       in_bytes;

    assign load     = !queue_empty && (!valid_reg || !result_stall);
    assign in_bytes = (idx_reg < head.count);
    assign pop      = load && last_next;

    always_comb
    begin
        kind_next = KIND_BYTE;
        byte_next = 8'd0;
        end_next  = 1'b0;
        err_next  = ERR_BAD_SINGLE;
        last_next = 1'b1;
        if (in_bytes)
        begin
            byte_next = head.data[idx_reg];
            last_next = (idx_reg == head.count - 3'd1) && (head.tail == TAIL_NONE);
            end_next  = head.end_mark && (idx_reg == head.count - 3'd1);
        end
        else
        begin
            case (head.tail)
                TAIL_FLOW:
                    kind_next = KIND_FLOW;
                TAIL_ERROR:
                begin
                    kind_next = KIND_ERROR;
                    err_next  = head.err;
                end
                default:
                    kind_next = KIND_BYTE;
            endcase
        end
        idx_next = last_next ? 3'd0 : idx_reg + 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 3'd0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                idx_reg   <= idx_next;
            end
            else if (!result_stall)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg <= kind_next;
            byte_reg <= byte_next;
            end_reg  <= end_next;
            err_reg  <= err_next;
            last_reg <= last_next;
        end
    end

    assign result_valid = valid_reg;
    assign kind         = kind_reg;
    assign payload_byte = byte_reg;
    assign message_end  = end_reg;
    assign error_code   = err_reg;
    assign run_last     = last_reg;

endmodule
